### sv/br1_pkg.sv
// Shared types and constants of the ByteRun1 bitmap decoder.
package br1_pkg;

    localparam logic [7:0] NOOP_HEADER = 8'h80;
    localparam int unsigned CFG_INDEX_W = 3;

    typedef enum logic [1:0] {
        PHASE_HEADER  = 2'd0,
        PHASE_LITERAL = 2'd1,
        PHASE_REPEAT  = 2'd2
    } phase_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COMPRESSED_MODE = 3'd0,
        CFG_IMAGE_WIDTH     = 3'd1,
        CFG_IMAGE_HEIGHT    = 3'd2,
        CFG_DEST_WIDTH      = 3'd3,
        CFG_DEST_HEIGHT     = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       start_image;
    } body_item_t;

    typedef struct packed {
        logic [15:0] row_index;
        logic [15:0] start_column;
        logic [7:0]  run_length;
        logic [7:0]  pixel_value;
        logic        image_done;
    } run_item_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [15:0]            wdata;
    } cfg_write_t;

    typedef struct packed {
        logic        compressed_mode;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [15:0] dest_width;
        logic [15:0] dest_height;
    } cfg_regs_t;

endpackage

### sv/br1_body_if.sv
// Handshake channel that carries body bytes.
interface br1_body_if;
    import br1_pkg::*;

    logic       valid;
    logic       ready;
    body_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/br1_run_if.sv
// Handshake channel that carries clipped pixel-run writes.
interface br1_run_if;
    import br1_pkg::*;

    logic      valid;
    logic      ready;
    run_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/br1_cfg_if.sv
// Handshake channel that carries configuration register writes.
interface br1_cfg_if;
    import br1_pkg::*;

    logic       valid;
    logic       ready;
    cfg_write_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/br1_cfg.sv
// Configuration register file of the ByteRun1 bitmap decoder.
module br1_cfg (
    input  logic                clk,
    input  logic                rst_n,
    br1_cfg_if.sink             cfg,
    output br1_pkg::cfg_regs_t  regs
);
    import br1_pkg::*;

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.data.reg_index)
                CFG_COMPRESSED_MODE: regs_next.compressed_mode = cfg.data.wdata[0];
                CFG_IMAGE_WIDTH:     regs_next.image_width     = cfg.data.wdata;
                CFG_IMAGE_HEIGHT:    regs_next.image_height    = cfg.data.wdata;
                CFG_DEST_WIDTH:      regs_next.dest_width      = cfg.data.wdata;
                CFG_DEST_HEIGHT:     regs_next.dest_height     = cfg.data.wdata;
                default:             regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end
endmodule

### sv/br1_in_reg.sv
// Input register stage that holds one body byte ahead of the decoder.
module br1_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    br1_body_if.sink   body_in,
    br1_body_if.source item_out
);
    import br1_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    body_item_t data_reg;
    logic       load;

    assign body_in.ready  = !valid_reg || item_out.ready;
    assign load           = body_in.valid && body_in.ready;
    assign item_out.valid = valid_reg;
    assign item_out.data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (item_out.ready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= body_in.data;
        end
    end
endmodule

### sv/br1_step.sv
// Decode state, run clipping and result register of the ByteRun1 decoder.
module br1_step (
    input  logic               clk,
    input  logic               rst_n,
    input  br1_pkg::cfg_regs_t regs,
    br1_body_if.sink           item_in,
    br1_run_if.source          run_out
);
    import br1_pkg::*;

    logic [15:0] row_reg;
    logic [15:0] row_next;
    logic [16:0] col_reg;
    logic [16:0] col_next;
    phase_t      phase_reg;
    phase_t      phase_next;
    logic [7:0]  pend_reg;
    logic [7:0]  pend_next;
    logic        fin_reg;
    logic        fin_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    run_item_t   out_data_reg;
    run_item_t   out_data_next;

    logic        advance;
    logic [15:0] row_e;
    logic [16:0] col_e;
    phase_t      phase_e;
    logic [7:0]  pend_e;
    logic        fin_e;
    logic        active;
    logic [7:0]  byte_in;
    logic [7:0]  len;
    logic [7:0]  pend_dec;
    logic        run_over;
    logic        emit;
    logic        in_dest;
    logic [16:0] room;
    logic [16:0] col_sum;
    logic [15:0] row_inc;

    assign item_in.ready = !out_valid_reg || run_out.ready;
    assign advance       = item_in.valid && item_in.ready;
    assign run_out.valid = out_valid_reg;
    assign run_out.data  = out_data_reg;

    assign byte_in  = item_in.data.body_byte;
    assign row_e    = item_in.data.start_image ? 16'd0 : row_reg;
    assign col_e    = item_in.data.start_image ? 17'd0 : col_reg;
    assign phase_e  = item_in.data.start_image ? PHASE_HEADER : phase_reg;
    assign pend_e   = item_in.data.start_image ? 8'd0 : pend_reg;
    assign fin_e    = item_in.data.start_image ? 1'b0 : fin_reg;
    assign active   = !fin_e && (regs.image_width != 16'd0) && (row_e < regs.image_height);
    assign pend_dec = pend_e - 8'd1;

    // Run decode and phase sequencing.
    always_comb
    begin
        len        = 8'd1;
        run_over   = 1'b1;
        emit       = 1'b0;
        phase_next = phase_e;
        pend_next  = pend_e;
        if (active)
        begin
            if (regs.compressed_mode)
            begin
                case (phase_e)
                    PHASE_LITERAL:
                    begin
                        emit = 1'b1;
                        if (pend_e != 8'd0)
                        begin
                            pend_next = pend_dec;
                            run_over  = (pend_dec == 8'd0);
                        end
                    end
                    PHASE_REPEAT:
                    begin
                        emit = 1'b1;
                        len  = pend_e;
                    end
                    default:
                    begin
                        if (byte_in > NOOP_HEADER)
                        begin
                            pend_next  = 8'(9'd257 - {1'b0, byte_in});
                            phase_next = PHASE_REPEAT;
                        end
                        else if (byte_in < NOOP_HEADER)
                        begin
                            pend_next  = byte_in + 8'd1;
                            phase_next = PHASE_LITERAL;
                        end
                    end
                endcase
            end
            else
            begin
                emit = 1'b1;
            end
            if (emit && run_over)
            begin
                phase_next = PHASE_HEADER;
                pend_next  = 8'd0;
            end
        end
    end

    // Clipping, position update and result.
    always_comb
    begin
        in_dest  = (row_e < regs.dest_height) && (col_e < {1'b0, regs.dest_width});
        room     = {1'b0, regs.dest_width} - col_e;
        col_sum  = col_e + {9'd0, len};
        row_inc  = row_e + 16'd1;
        row_next = row_e;
        col_next = col_e;
        fin_next = fin_e;

        out_data_next.row_index    = row_e;
        out_data_next.start_column = col_e[16] ? 16'hFFFF : col_e[15:0];
        out_data_next.pixel_value  = byte_in;
        out_data_next.image_done   = 1'b0;
        if (!in_dest)
        begin
            out_data_next.run_length = 8'd0;
        end
        else if ({9'd0, len} < room)
        begin
            out_data_next.run_length = len;
        end
        else
        begin
            out_data_next.run_length = room[7:0];
        end

        if (emit)
        begin
            col_next = col_sum;
            if (run_over && (col_sum >= {1'b0, regs.image_width}))
            begin
                col_next = 17'd0;
                row_next = row_inc;
                if ((row_inc >= regs.image_height) || (row_inc == 16'd0))
                begin
                    fin_next                 = 1'b1;
                    out_data_next.image_done = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (run_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= 16'd0;
            col_reg       <= 17'd0;
            phase_reg     <= PHASE_HEADER;
            pend_reg      <= 8'd0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                row_reg   <= row_next;
                col_reg   <= col_next;
                phase_reg <= phase_next;
                pend_reg  <= pend_next;
                fin_reg   <= fin_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    a_done_sets_finished: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit && out_data_next.image_done) |=> fin_reg)
        else $error("finished flag not set after the final row");

    a_header_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PHASE_HEADER) |-> (pend_reg == 8'd0))
        else $error("pending count left over in header phase");

    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.run_length <= 8'd128))
        else $error("run length above 128");

    a_saturated_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.start_column == 16'hFFFF))
        |-> (out_data_reg.run_length == 8'd0))
        else $error("run at saturated column not fully clipped");
endmodule

### sv/byterun1_bitmap_decoder_top.sv
// Top level of the ByteRun1 bitmap body decoder.
// The decoder takes BODY payload bytes of an 8-bit bitmap on the body_in channel, one per
// transfer, and returns clipped pixel-run writes on the run_out channel. A header byte in
// compressed mode, a no-op byte, any byte after the final row or with a zero image width
// give no run; every other byte gives exactly one run, which may have zero length when it
// falls outside the destination. Setting start_image with a byte clears row, column and run
// state first. The cfg channel writes the five configuration registers by index; it is
// always ready and should be used only while no byte is in flight.
// A byte accepted on body_in sits in the input register, is then decoded into the result
// register, and its run can be transferred from there. One byte per cycle is sustained
// while the receiver takes every run: the decode is a single pass of compare, subtract and
// clip against the registered row and column counters.
// Reset clears the configuration registers, the decode state and both stage valid flags.
// When the receiver stalls, the run waits in the result register and the input register
// still takes one more byte; after that body_in.ready stays low until the run is taken.
module byterun1_bitmap_decoder_top (
    input  logic      clk,
    input  logic      rst_n,
    br1_cfg_if.sink   cfg,
    br1_body_if.sink  body_in,
    br1_run_if.source run_out
);
    import br1_pkg::*;

    cfg_regs_t  regs;
    br1_body_if stage_if ();

    br1_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    br1_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .body_in  (body_in),
        .item_out (stage_if.source)
    );

    br1_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .regs    (regs),
        .item_in (stage_if.sink),
        .run_out (run_out)
    );
endmodule

### bench/byterun1_bitmap_decoder_top_tb.sv
// Self-checking testbench for the ByteRun1 bitmap decoder that predicts every run transfer.
module byterun1_bitmap_decoder_top_tb;
    import br1_pkg::*;

    localparam int RUN_LIMIT = 2_000_000;
    localparam int RANDOM_BYTES = 600;

    logic clk;
    logic rst_n;

    br1_cfg_if  cfg_bus ();
    br1_body_if body_bus ();
    br1_run_if  run_bus ();

    byterun1_bitmap_decoder_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .body_in (body_bus),
        .run_out (run_bus)
    );

    body_item_t  byte_queue[$];
    run_item_t   runs_due[$];
    cfg_regs_t   shadow_regs;
    logic [15:0] row_pos;
    logic [16:0] col_pos;
    phase_t      run_phase;
    logic [7:0]  run_left;
    logic        image_over;
    logic        start_next;
    int          send_idle_pct;
    int          stall_pct;
    int          error_count;

    function automatic bit log_slot();
        log_slot = (error_count < 10);
        error_count++;
    endfunction

    function automatic void clear_image();
        row_pos = '0;
        col_pos = '0;
        run_phase = PHASE_HEADER;
        run_left = '0;
        image_over = 1'b0;
    endfunction

    function automatic void decode_body_byte(body_item_t item);
        run_item_t   run;
        logic [7:0]  span;
        logic [7:0]  fit;
        logic [16:0] room;
        logic        ends_run;
        logic        done;
        done = 1'b0;
        fit = '0;
        if (item.start_image)
            clear_image();
        if (image_over || shadow_regs.image_width == 0 || row_pos >= shadow_regs.image_height)
            return;
        if (shadow_regs.compressed_mode)
        begin
            if (run_phase == PHASE_LITERAL && run_left != 0)
            begin
                span = 8'd1;
                run_left = run_left - 8'd1;
                ends_run = (run_left == 0);
            end
            else if (run_phase == PHASE_REPEAT)
            begin
                span = run_left;
                ends_run = 1'b1;
            end
            else if (run_phase == PHASE_LITERAL)
            begin
                span = 8'd1;
                ends_run = 1'b1;
            end
            else
            begin
                if (item.body_byte == NOOP_HEADER)
                    return;
                if (item.body_byte > NOOP_HEADER)
                begin
                    run_left = 8'(9'd257 - {1'b0, item.body_byte});
                    run_phase = PHASE_REPEAT;
                end
                else
                begin
                    run_left = item.body_byte + 8'd1;
                    run_phase = PHASE_LITERAL;
                end
                return;
            end
        end
        else
        begin
            span = 8'd1;
            ends_run = 1'b1;
        end
        if (row_pos < shadow_regs.dest_height && col_pos < {1'b0, shadow_regs.dest_width})
        begin
            room = {1'b0, shadow_regs.dest_width} - col_pos;
            fit = ({9'd0, span} < room) ? span : room[7:0];
        end
        run.row_index = row_pos;
        run.start_column = (col_pos > 17'h0FFFF) ? 16'hFFFF : col_pos[15:0];
        run.run_length = fit;
        run.pixel_value = item.body_byte;
        col_pos = col_pos + {9'd0, span};
        if (ends_run)
        begin
            run_phase = PHASE_HEADER;
            run_left = '0;
            if (col_pos >= {1'b0, shadow_regs.image_width})
            begin
                col_pos = '0;
                row_pos = row_pos + 16'd1;
                if (row_pos >= shadow_regs.image_height || row_pos == 0)
                begin
                    image_over = 1'b1;
                    done = 1'b1;
                end
            end
        end
        run.image_done = done;
        runs_due.push_back(run);
    endfunction

    function automatic void push_byte(logic [7:0] value, logic start);
        body_item_t item;
        item.body_byte = value;
        item.start_image = start | start_next;
        start_next = 1'b0;
        byte_queue.push_back(item);
    endfunction

    function automatic logic [7:0] literal_header(int count);
        return 8'(count - 1);
    endfunction

    function automatic logic [7:0] repeat_header(int count);
        return 8'(257 - count);
    endfunction

    function automatic void set_idling(int sel);
        case (sel % 4)
            0:
            begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 57;
                stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                stall_pct = 57;
            end
            default:
            begin
                send_idle_pct = 31;
                stall_pct = 31;
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_size(int lo, int hi);
        case ($urandom_range(0, 19))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data <= {idx, value};
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (idx)
            CFG_COMPRESSED_MODE: shadow_regs.compressed_mode = value[0];
            CFG_IMAGE_WIDTH:     shadow_regs.image_width = value;
            CFG_IMAGE_HEIGHT:    shadow_regs.image_height = value;
            CFG_DEST_WIDTH:      shadow_regs.dest_width = value;
            CFG_DEST_HEIGHT:     shadow_regs.dest_height = value;
            default: ;
        endcase
    endtask

    task automatic load_setup(input bit mode, input logic [15:0] iw, input logic [15:0] ih,
                              input logic [15:0] dw, input logic [15:0] dh);
        write_reg(CFG_COMPRESSED_MODE, {15'd0, mode});
        write_reg(CFG_IMAGE_WIDTH, iw);
        write_reg(CFG_IMAGE_HEIGHT, ih);
        write_reg(CFG_DEST_WIDTH, dw);
        write_reg(CFG_DEST_HEIGHT, dh);
    endtask

    task automatic drain();
        do @(posedge clk); while (byte_queue.size() != 0 || body_bus.valid || runs_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_image(input bit fresh, inout int produced);
        int rows_done;
        int col;
        int sent;
        int pick;
        int n;
        int extras;
        rows_done = 0;
        col = 0;
        sent = 0;
        start_next = fresh;
        while (rows_done < int'(shadow_regs.image_height) && sent < 160)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                push_byte(8'($urandom), $urandom_range(0, 3) == 0);
                sent++;
            end
            else if (!shadow_regs.compressed_mode)
            begin
                push_byte(8'($urandom), 1'b0);
                sent++;
                col++;
            end
            else if (pick < 9)
            begin
                push_byte(NOOP_HEADER, 1'b0);
                sent++;
            end
            else if (pick < 55)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
                push_byte(literal_header(n), 1'b0);
                repeat (n) push_byte(8'($urandom), 1'b0);
                sent += n + 1;
                col += n;
            end
            else
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 128) : $urandom_range(2, 12);
                push_byte(repeat_header(n), 1'b0);
                push_byte(8'($urandom), 1'b0);
                sent += 2;
                col += n;
            end
            if (col >= int'(shadow_regs.image_width))
            begin
                col = 0;
                rows_done++;
            end
        end
        // A lone header leaves a run pending for whatever the next setting makes of it.
        if (shadow_regs.compressed_mode && $urandom_range(0, 9) == 0)
        begin
            if ($urandom_range(0, 1))
                push_byte(literal_header($urandom_range(1, 128)), 1'b0);
            else
                push_byte(repeat_header($urandom_range(2, 128)), 1'b0);
            sent++;
        end
        extras = $urandom_range(0, 3);
        repeat (extras) push_byte(8'($urandom), 1'b0);
        produced += sent + extras;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_bus.valid <= 1'b0;
            body_bus.data <= '0;
        end
        else
        begin
            if (body_bus.valid && body_bus.ready)
                decode_body_byte(body_bus.data);
            if (!body_bus.valid || body_bus.ready)
            begin
                if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    body_bus.valid <= 1'b1;
                    body_bus.data <= byte_queue.pop_front();
                end
                else
                begin
                    body_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : run_check
        run_item_t want;
        run_item_t got;
        if (!rst_n)
        begin
            run_bus.ready <= 1'b0;
        end
        else
        begin
            if (run_bus.valid && run_bus.ready)
            begin
                got = run_bus.data;
                if (runs_due.size() == 0)
                begin
                    if (log_slot())
                        $display("%0t: unexpected run row %0d col %0d len %0d pixel %0h done %0b",
                                 $realtime, got.row_index, got.start_column, got.run_length,
                                 got.pixel_value, got.image_done);
                end
                else
                begin
                    want = runs_due.pop_front();
                    if (got.row_index !== want.row_index || got.start_column !== want.start_column
                        || got.run_length !== want.run_length
                        || got.pixel_value !== want.pixel_value
                        || got.image_done !== want.image_done)
                    begin
                        if (log_slot())
                            $display({"%0t: run mismatch, expected row %0d col %0d len %0d ",
                                      "pixel %0h done %0b, got row %0d col %0d len %0d ",
                                      "pixel %0h done %0b"},
                                     $realtime, want.row_index, want.start_column,
                                     want.run_length, want.pixel_value, want.image_done,
                                     got.row_index, got.start_column, got.run_length,
                                     got.pixel_value, got.image_done);
                    end
                end
            end
            run_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("byterun1_bitmap_decoder_top_tb: done, errors");
        $finish;
    end

    initial
    begin
        int produced;
        int phase_no;
        bit fresh;
        rst_n <= 1'b0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.data <= '0;
        shadow_regs = '0;
        clear_image();
        start_next = 1'b0;
        error_count = 0;
        produced = 0;
        set_idling(0);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Raw bytes are clipped at the destination edges, and bytes after the final row
        // are dropped until a restart.
        load_setup(1'b0, 16'd3, 16'd2, 16'd2, 16'd1);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(NOOP_HEADER, 1'b0);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b1);
        drain();

        // The longest repeat overruns its row, and the final row falls outside the destination.
        set_idling(3);
        load_setup(1'b1, 16'd5, 16'd3, 16'd4, 16'd2);
        push_byte(NOOP_HEADER, 1'b1);
        push_byte(literal_header(1), 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(repeat_header(128), 1'b0);
        push_byte(8'h7E, 1'b0);
        push_byte(literal_header(3), 1'b0);
        push_byte(8'h11, 1'b0);
        push_byte(8'h22, 1'b0);
        push_byte(8'h33, 1'b0);
        push_byte(repeat_header(3), 1'b0);
        push_byte(8'h44, 1'b0);
        push_byte(repeat_header(2), 1'b0);
        push_byte(8'h66, 1'b0);
        push_byte(repeat_header(6), 1'b0);
        push_byte(8'h77, 1'b0);
        drain();

        // With a zero image width bytes are dropped, and an unknown index changes nothing.
        write_reg(CFG_IMAGE_WIDTH, 16'd0);
        write_reg(cfg_index_t'(CFG_DEST_HEIGHT + 1 + $urandom_range(0, 2)), 16'($urandom));
        push_byte(8'h09, 1'b1);
        drain();

        phase_no = 0;
        while (produced < RANDOM_BYTES)
        begin
            set_idling(phase_no);
            if (phase_no == 3)
            begin
                // A row at the widest image width pushes the column past 16 bits.
                load_setup(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
                start_next = 1'b1;
                repeat (511)
                begin
                    push_byte(repeat_header(128), 1'b0);
                    push_byte(8'($urandom), 1'b0);
                end
                push_byte(repeat_header(100), 1'b0);
                push_byte(8'($urandom), 1'b0);
                push_byte(literal_header(128), 1'b0);
                repeat (128) push_byte(8'($urandom), 1'b0);
                push_byte(repeat_header(128), 1'b0);
                push_byte(8'($urandom), 1'b0);
                produced += byte_queue.size();
            end
            else
            begin
                if (phase_no > 0 && $urandom_range(0, 4) == 0)
                begin
                    if ($urandom_range(0, 1))
                        write_reg(CFG_COMPRESSED_MODE, {15'd0, ~shadow_regs.compressed_mode});
                    else
                        write_reg(CFG_IMAGE_HEIGHT, 16'($urandom_range(0, 3)));
                    fresh = $urandom_range(0, 1);
                end
                else
                begin
                    load_setup($urandom_range(0, 3) != 0, pick_size(1, 24), pick_size(1, 5),
                               pick_size(1, 30), pick_size(1, 6));
                    fresh = ($urandom_range(0, 9) != 0);
                end
                queue_image(fresh, produced);
            end
            drain();
            phase_no++;
        end

        drain();
        if (runs_due.size() != 0)
        begin
            if (log_slot())
                $display("%0d expected runs never arrived", runs_due.size());
        end
        if (error_count == 0)
            $display("byterun1_bitmap_decoder_top_tb: done, clean");
        else
            $display("byterun1_bitmap_decoder_top_tb: done, errors");
        $finish;
    end
endmodule
